// ----- src/bf3_pkg.sv -----
// Shared types and constants for the 3x3 box filter.
package bf3_pkg;

  // Configuration register file
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 11'd3;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 11'd3;
  localparam int               HEIGHT_LIMIT      = 1024;

  // Result queue depth
  localparam int OUT_DEPTH = 8;

  // Per-item window control, carried along the pipeline
  typedef struct packed {
    logic mid_ok;    // row above the newest row lies inside the grid
    logic up_ok;     // row two above the newest row lies inside the grid
    logic right_en;  // right column of the window lies inside the grid
    logic left_en;   // left column of the window lies inside the grid
    logic emit;      // this item produces a result
    logic last;      // this result closes the frame
  } win_ctl_t;

endpackage

// ----- src/bf3_in_if.sv -----
// Input request channel: grid cells and flush items.
interface bf3_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [VALUE_BITS-1:0] cell_value;

  modport source (output valid, kind, cell_value, input ready);
  modport sink   (input valid, kind, cell_value, output ready);
endinterface

// ----- src/bf3_out_if.sv -----
// Result request channel: filtered cells.
interface bf3_out_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] filtered_value;
  logic                  frame_end;

  modport source (output valid, filtered_value, frame_end, input ready);
  modport sink   (input valid, filtered_value, frame_end, output ready);
endinterface

// ----- src/bf3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bf3_ctrl.sv -----
// Input side: config registers, raster cursor, result position and per-item window flags.
module bf3_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]       cfg_data,
  bf3_in_if.sink                          in_ch,
  input  logic                            space,
  output logic                            item_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]    item_col,
  output logic [VALUE_BITS-1:0]           item_value,
  output bf3_pkg::win_ctl_t               item_ctl,
  output logic                            claim
);
  import bf3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CMP_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int LEAD_W = CFG_W + 1;
  localparam logic [VALUE_BITS-1:0] VALUE_ONE = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CFG_W-1:0]  row_r, row_nxt;
  logic [LEAD_W-1:0] lead_r, lead_nxt;
  logic [COL_W-1:0]  oc_col_r, oc_col_nxt;
  logic [CFG_W-1:0]  oc_row_r, oc_row_nxt;

  logic [CFG_W-1:0]  eff_w, eff_h;
  logic              in_frame, accept, processed, emit, col_end, oc_col_end, oc_last;

  // Effective grid size: zero acts as one, oversize clamps
  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = CFG_W'(1);
    end else if (int'(height_r) > HEIGHT_LIMIT) begin
      eff_h = CFG_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_r;
    end
  end

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_frame    = row_r < eff_h;
  // A flush inside the frame is dropped; a cell past the frame acts as flush
  assign processed   = accept && !(in_frame && in_ch.kind);
  assign emit        = lead_r == ({1'b0, eff_w} + LEAD_W'(1));
  assign col_end     = (CMP_W'(col_r) + CMP_W'(1)) == CMP_W'(eff_w);
  assign oc_col_end  = (CMP_W'(oc_col_r) + CMP_W'(1)) == CMP_W'(eff_w);
  assign oc_last     = oc_col_end && ((oc_row_r + CFG_W'(1)) == eff_h);

  // Item handed to the line buffers
  assign item_valid = processed;
  assign item_col   = col_r;
  assign claim      = processed && emit;

  always_comb begin
    if (!in_frame) begin
      item_value = '0;
    end else if (in_ch.cell_value > VALUE_ONE) begin
      item_value = VALUE_ONE;
    end else begin
      item_value = in_ch.cell_value;
    end
  end

  // Window flags for the result this item completes
  always_comb begin
    item_ctl.mid_ok   = (row_r != '0) && (row_r <= eff_h);
    item_ctl.up_ok    = (row_r >= CFG_W'(2)) &&
                        ({1'b0, row_r} <= ({1'b0, eff_h} + LEAD_W'(1)));
    item_ctl.right_en = col_r != '0;
    item_ctl.left_en  = (col_r == '0) ? (eff_w >= CFG_W'(2)) : (col_r >= COL_W'(2));
    item_ctl.emit     = emit;
    item_ctl.last     = oc_last;
  end

  // Next state of registers and cursors
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    lead_nxt   = lead_r;
    oc_col_nxt = oc_col_r;
    oc_row_nxt = oc_row_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  width_nxt  = cfg_data;
        REG_GRID_HEIGHT: height_nxt = cfg_data;
      endcase
      col_nxt    = '0;
      row_nxt    = '0;
      lead_nxt   = '0;
      oc_col_nxt = '0;
      oc_row_nxt = '0;
    end else if (processed) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_r + CFG_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (!emit) begin
        lead_nxt = lead_r + LEAD_W'(1);
      end else if (oc_last) begin
        // last result: start a new frame
        col_nxt    = '0;
        row_nxt    = '0;
        lead_nxt   = '0;
        oc_col_nxt = '0;
        oc_row_nxt = '0;
      end else if (oc_col_end) begin
        oc_col_nxt = '0;
        oc_row_nxt = oc_row_r + CFG_W'(1);
      end else begin
        oc_col_nxt = oc_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GRID_WIDTH_RESET;
      height_r <= GRID_HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      lead_r   <= '0;
      oc_col_r <= '0;
      oc_row_r <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lead_r   <= lead_nxt;
      oc_col_r <= oc_col_nxt;
      oc_row_r <= oc_row_nxt;
    end
  end

endmodule

// ----- src/bf3_lbuf.sv -----
// Line buffers: two row memories, read-shift-write per column, vertical 3-cell sum.
module bf3_lbuf #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  bf3_pkg::win_ctl_t            in_ctl,
  output logic                         cs_valid,
  output logic [VALUE_BITS:0]          cs_sum,
  output bf3_pkg::win_ctl_t            cs_ctl
);
  import bf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CS_W  = VALUE_BITS + 1;

  // Read stage
  logic                  s1_valid_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [VALUE_BITS-1:0] s1_value_r;
  win_ctl_t              s1_ctl_r;

  // Last write, for a read issued on the same edge
  logic                  fw_valid_r;
  logic [COL_W-1:0]      fw_col_r;
  logic [VALUE_BITS-1:0] fw_mid_r;
  logic [VALUE_BITS-1:0] fw_up_r;

  logic [VALUE_BITS-1:0] mid_rdata, up_rdata, mid_eff, up_eff;
  logic                  fw_hit;
  logic [CS_W-1:0]       cs_nxt;

  logic                  s2_valid_r;
  logic [CS_W-1:0]       s2_cs_r;
  win_ctl_t              s2_ctl_r;

  // Middle row: newest completed row; upper row: the one before
  bf3_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_value_r),
    .re    (in_valid),
    .raddr (in_col),
    .rdata (mid_rdata)
  );

  bf3_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (mid_eff),
    .re    (in_valid),
    .raddr (in_col),
    .rdata (up_rdata)
  );

  // Forward the column written on the read edge (single-column grids)
  assign fw_hit  = fw_valid_r && (fw_col_r == s1_col_r);
  assign mid_eff = fw_hit ? fw_mid_r : mid_rdata;
  assign up_eff  = fw_hit ? fw_up_r  : up_rdata;

  // Vertical sum, rows outside the grid count as zero
  always_comb begin
    cs_nxt = CS_W'(s1_value_r);
    if (s1_ctl_r.mid_ok) begin
      cs_nxt = cs_nxt + CS_W'(mid_eff);
    end
    if (s1_ctl_r.up_ok) begin
      cs_nxt = cs_nxt + CS_W'(up_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      fw_valid_r <= s1_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= in_col;
    s1_value_r <= in_value;
    s1_ctl_r   <= in_ctl;
    fw_col_r   <= s1_col_r;
    fw_mid_r   <= s1_value_r;
    fw_up_r    <= mid_eff;
    s2_cs_r    <= cs_nxt;
    s2_ctl_r   <= s1_ctl_r;
  end

  assign cs_valid = s2_valid_r;
  assign cs_sum   = s2_cs_r;
  assign cs_ctl   = s2_ctl_r;

endmodule

// ----- src/bf3_avg.sv -----
// Horizontal window of column sums and rounded divide by nine.
module bf3_avg #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cs_valid,
  input  logic [VALUE_BITS:0]   cs_sum,
  input  bf3_pkg::win_ctl_t     cs_ctl,
  output logic                  res_valid,
  output logic [VALUE_BITS-1:0] res_value,
  output logic                  res_last
);
  import bf3_pkg::*;

  localparam int CS_W  = VALUE_BITS + 1;
  localparam int SUM_W = VALUE_BITS + 3;
  localparam int SHIFT = SUM_W + 4;
  localparam int MW    = SUM_W + 2;
  localparam int LO_W  = MW / 2;
  localparam int HI_W  = MW - LO_W;
  localparam int PW    = SUM_W + MW;
  // ceil(2^SHIFT / 9): exact quotient for every sum below 2^SUM_W
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) + 64'd8) / 64'd9);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[MW-1:LO_W];

  logic [CS_W-1:0]        center_r, left_r;
  logic [SUM_W-1:0]       win_nxt;

  logic                   s3_valid_r, s3_last_r;
  logic [SUM_W-1:0]       s3_sum_r;

  logic                   s4_valid_r, s4_last_r;
  logic [SUM_W+LO_W-1:0]  p_lo_r;
  logic [SUM_W+HI_W-1:0]  p_hi_r;
  logic [PW-1:0]          prod;

  // Window sum plus rounding offset
  always_comb begin
    win_nxt = SUM_W'(center_r) + SUM_W'(4);
    if (cs_ctl.right_en) begin
      win_nxt = win_nxt + SUM_W'(cs_sum);
    end
    if (cs_ctl.left_en) begin
      win_nxt = win_nxt + SUM_W'(left_r);
    end
  end

  // Column sum shift: every item moves the window one column
  always_ff @(posedge clk) begin
    if (cs_valid) begin
      center_r <= cs_sum;
      left_r   <= center_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= cs_valid && cs_ctl.emit;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Reciprocal multiply in two partial products
  always_ff @(posedge clk) begin
    s3_sum_r  <= win_nxt;
    s3_last_r <= cs_ctl.last;
    p_lo_r    <= {{LO_W{1'b0}}, s3_sum_r} * {{SUM_W{1'b0}}, RECIP_LO};
    p_hi_r    <= {{HI_W{1'b0}}, s3_sum_r} * {{SUM_W{1'b0}}, RECIP_HI};
    s4_last_r <= s3_last_r;
  end

  assign prod      = (PW'(p_hi_r) << LO_W) + PW'(p_lo_r);
  assign res_valid = s4_valid_r;
  assign res_value = prod[SHIFT +: VALUE_BITS];
  assign res_last  = s4_last_r;

endmodule

// ----- src/bf3_oq.sv -----
// Result queue with credit count for results still in flight.
module bf3_oq #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  claim,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] push_value,
  input  logic                  push_last,
  output logic                  space,
  bf3_out_if.source             out_ch
);
  import bf3_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [VALUE_BITS:0] q_mem [OUT_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r, pend_r;
  logic                pop;

  assign out_ch.valid          = count_r != '0;
  assign pop                   = out_ch.valid && out_ch.ready;
  assign out_ch.filtered_value = q_mem[rd_ptr_r][VALUE_BITS-1:0];
  assign out_ch.frame_end      = q_mem[rd_ptr_r][VALUE_BITS];
  // Results owed (in pipeline or queued) never exceed the queue depth
  assign space                 = pend_r < CNT_W'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= {push_last, push_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      pend_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
      pend_r  <= pend_r + CNT_W'(claim) - CNT_W'(pop);
    end
  end

endmodule

// ----- src/box_filter_3x3_zero_pad.sv -----
// 3x3 box filter with zero padding: streaming, one cell per clock while in_ch.ready is high.
//
// Usage:
//   in_ch carries grid cells in raster order (kind = 0, unsigned Q1.15,
//   values above 1.0 saturate) and, after the frame, grid_width + 1
//   flush items (kind = 1) that push out the last results. out_ch
//   carries the rounded 3x3 average of each cell, frame_end on the last.
//   The cfg port writes grid_width (index 0) and grid_height (index 1)
//   while the block is idle; each write starts a new frame.
// Timing:
//   One item per clock while in_ch.ready is high. The result for cell k
//   comes with the item that brings cell k + grid_width + 1 and reaches
//   out_ch after the row memory read on the accepting edge, the column
//   sum, window sum, partial products and result queue registers.
// Reset:
//   Registers return to 3 x 3 and the cursor to the frame start. Row
//   memories are not cleared; only entries written in the current frame
//   are read.
// Stall:
//   An 8-entry result queue decouples the sides; in_ch.ready drops only
//   while eight results are owed to the receiver.
module box_filter_3x3_zero_pad #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]     cfg_data,
  bf3_in_if.sink                        in_ch,
  bf3_out_if.source                     out_ch
);
  import bf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                  item_valid, claim, space;
  logic [COL_W-1:0]      item_col;
  logic [VALUE_BITS-1:0] item_value;
  win_ctl_t              item_ctl;

  logic                  cs_valid;
  logic [VALUE_BITS:0]   cs_sum;
  win_ctl_t              cs_ctl;

  logic                  res_valid, res_last;
  logic [VALUE_BITS-1:0] res_value;

  bf3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .space      (space),
    .item_valid (item_valid),
    .item_col   (item_col),
    .item_value (item_value),
    .item_ctl   (item_ctl),
    .claim      (claim)
  );

  bf3_lbuf #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_lbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (item_valid),
    .in_col   (item_col),
    .in_value (item_value),
    .in_ctl   (item_ctl),
    .cs_valid (cs_valid),
    .cs_sum   (cs_sum),
    .cs_ctl   (cs_ctl)
  );

  bf3_avg #(.VALUE_BITS(VALUE_BITS)) u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cs_valid  (cs_valid),
    .cs_sum    (cs_sum),
    .cs_ctl    (cs_ctl),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_last  (res_last)
  );

  bf3_oq #(.VALUE_BITS(VALUE_BITS)) u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .claim      (claim),
    .push       (res_valid),
    .push_value (res_value),
    .push_last  (res_last),
    .space      (space),
    .out_ch     (out_ch)
  );

endmodule
